FILE: rtl/ihp_pkg.sv
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types, codes and compare function for the indexed min-heap.
// ----------------------------------------------------------------------------
package ihp_pkg;

  localparam int KEY_W    = 16;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } slot_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEL_RD,
    S_POP_RD,
    S_UP,
    S_UP_CMP,
    S_RM,
    S_RM_LAST,
    S_DN,
    S_DN_CMP,
    S_DONE
  } state_t;

  // key order, ties broken by the smaller id
  function automatic logic slot_less(input slot_t a, input slot_t b);
    slot_less = (a.key < b.key) || ((a.key == b.key) && (a.id < b.id));
  endfunction

endpackage

FILE: rtl/ihp_heap_mem.sv
// ----------------------------------------------------------------------------
// ihp_heap_mem
// Heap slot storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ihp_heap_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  ihp_pkg::slot_t wdata,
  input  logic [AW-1:0]  raddr_a,
  input  logic [AW-1:0]  raddr_b,
  output ihp_pkg::slot_t rdata_a,
  output ihp_pkg::slot_t rdata_b
);
  import ihp_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/ihp_ctrl.sv
// ----------------------------------------------------------------------------
// ihp_ctrl
// Request sequencer: id position map, sift up and sift down over the slot
// memory, result registers.
// ----------------------------------------------------------------------------
module ihp_ctrl #(
  parameter int ID_COUNT = 16,
  parameter int KEY_BITS = 16,
  parameter int PW       = 4,
  parameter int CW       = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        operation,
  input  logic [ihp_pkg::KEY_W-1:0]         key_in,
  input  logic [ihp_pkg::ID_W-1:0]          id_in,
  output logic                              done,
  output logic [ihp_pkg::KEY_W-1:0]         key_out,
  output logic [ihp_pkg::ID_W-1:0]          id_out,
  output logic [ihp_pkg::STATUS_W-1:0]      status,
  output logic [ihp_pkg::COUNT_W-1:0]       count_out,
  output logic                              mem_we,
  output logic [PW-1:0]                     mem_waddr,
  output ihp_pkg::slot_t                    mem_wdata,
  output logic [PW-1:0]                     mem_raddr_a,
  output logic [PW-1:0]                     mem_raddr_b,
  input  ihp_pkg::slot_t                    mem_rdata_a,
  input  ihp_pkg::slot_t                    mem_rdata_b
);
  import ihp_pkg::*;

  localparam int MAP_DEPTH = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
  localparam int MIW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int XW        = PW + 2;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << KEY_BITS) - 64'd1);

  state_t state, state_next;

  logic [PW-1:0] map_pos   [MAP_DEPTH];
  logic          map_valid [MAP_DEPTH];

  logic          map_we;
  logic [MIW-1:0] map_idx;
  logic [PW-1:0] map_pos_w;
  logic          map_valid_w;

  logic [CW-1:0] count, count_next;
  logic [PW-1:0] p, p_next;
  slot_t         cur, cur_next;
  slot_t         top, top_next;
  logic          force_up, force_up_next;
  logic [KEY_W-1:0]    res_key, res_key_next;
  logic [ID_W-1:0]     res_id, res_id_next;
  logic [STATUS_W-1:0] res_status, res_status_next;

  logic [MIW-1:0] in_idx;
  logic          id_ok;
  logic [PW-1:0] parent;
  logic [XW-1:0] lchild, rchild;
  logic          l_ok, r_ok;
  logic [PW-1:0] del_pos;
  logic [CW-1:0] count_m1;
  slot_t         best;
  logic          best_l, best_r;

  assign in_idx   = id_in[MIW-1:0];
  assign id_ok    = (32'(id_in) < ID_COUNT);
  assign parent   = PW'((p - 1'b1) >> 1);
  assign lchild   = {1'b0, p, 1'b1};
  assign rchild   = lchild + 1'b1;
  assign l_ok     = lchild < XW'(count);
  assign r_ok     = rchild < XW'(count);
  assign count_m1 = count - 1'b1;
  assign del_pos  = (XW'(map_pos[in_idx]) >= XW'(count)) ? '0 : map_pos[in_idx];

  always_comb begin
    best   = cur;
    best_l = 1'b0;
    best_r = 1'b0;
    if (l_ok && slot_less(mem_rdata_a, best)) begin
      best   = mem_rdata_a;
      best_l = 1'b1;
    end
    if (r_ok && slot_less(mem_rdata_b, best)) begin
      best   = mem_rdata_b;
      best_l = 1'b0;
      best_r = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    p          <= p_next;
    cur        <= cur_next;
    top        <= top_next;
    force_up   <= force_up_next;
    res_key    <= res_key_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_DEPTH; i++) begin
        map_valid[i] <= 1'b0;
      end
    end else if (map_we) begin
      map_valid[map_idx] <= map_valid_w;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_pos[map_idx] <= map_pos_w;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    p_next          = p;
    cur_next        = cur;
    top_next        = top;
    force_up_next   = force_up;
    res_key_next    = res_key;
    res_id_next     = res_id;
    res_status_next = res_status;
    map_we          = 1'b0;
    map_idx         = in_idx;
    map_pos_w       = '0;
    map_valid_w     = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = p;
    mem_wdata       = cur;
    mem_raddr_a     = '0;
    mem_raddr_b     = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          res_status_next = ST_OK;
          res_id_next     = id_in;
          state_next      = S_DONE;
          case (operation)
            OP_PUSH: begin
              res_key_next = key_in & KEY_MASK;
              if (!id_ok) begin
                res_status_next = ST_ABSENT;
              end else if (32'(count) >= ID_COUNT) begin
                res_status_next = ST_FULL;
              end else if (map_valid[in_idx]) begin
                res_status_next = ST_DUP;
              end else begin
                p_next        = PW'(count);
                count_next    = count + 1'b1;
                cur_next      = '{key: key_in & KEY_MASK, id: id_in};
                force_up_next = 1'b0;
                map_we        = 1'b1;
                map_pos_w     = PW'(count);
                map_valid_w   = 1'b1;
                state_next    = S_UP;
              end
            end
            OP_DELETE: begin
              res_key_next = '0;
              if (!id_ok || !map_valid[in_idx]) begin
                res_status_next = ST_ABSENT;
              end else begin
                p_next        = del_pos;
                force_up_next = 1'b1;
                mem_raddr_a   = del_pos;
                state_next    = S_DEL_RD;
              end
            end
            default: begin
              res_key_next = '0;
              res_id_next  = '0;
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                mem_raddr_a = '0;
                state_next  = S_POP_RD;
              end
            end
          endcase
        end
      end
      S_DEL_RD: begin
        top_next   = mem_rdata_a;
        state_next = S_UP;
      end
      S_POP_RD: begin
        top_next   = mem_rdata_a;
        state_next = S_RM;
      end
      S_UP: begin
        if (p == '0) begin
          if (force_up) begin
            state_next = S_RM;
          end else begin
            mem_we     = 1'b1;
            map_we     = 1'b1;
            map_idx    = cur.id[MIW-1:0];
            map_pos_w  = p;
            map_valid_w = 1'b1;
            state_next = S_DONE;
          end
        end else begin
          mem_raddr_a = parent;
          state_next  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we      = 1'b1;
        map_we      = 1'b1;
        map_valid_w = 1'b1;
        if (force_up || slot_less(cur, mem_rdata_a)) begin
          mem_wdata  = mem_rdata_a;
          map_idx    = mem_rdata_a.id[MIW-1:0];
          map_pos_w  = p;
          p_next     = parent;
          state_next = S_UP;
        end else begin
          map_idx    = cur.id[MIW-1:0];
          map_pos_w  = p;
          state_next = S_DONE;
        end
      end
      S_RM: begin
        res_key_next = top.key;
        res_id_next  = top.id;
        count_next   = count_m1;
        map_we       = 1'b1;
        map_idx      = top.id[MIW-1:0];
        map_pos_w    = '0;
        map_valid_w  = 1'b0;
        if (count_m1 != '0) begin
          mem_raddr_a = PW'(count_m1);
          state_next  = S_RM_LAST;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RM_LAST: begin
        cur_next    = mem_rdata_a;
        p_next      = '0;
        map_we      = 1'b1;
        map_idx     = mem_rdata_a.id[MIW-1:0];
        map_pos_w   = '0;
        map_valid_w = 1'b1;
        state_next  = S_DN;
      end
      S_DN: begin
        mem_raddr_a = lchild[PW-1:0];
        mem_raddr_b = rchild[PW-1:0];
        state_next  = S_DN_CMP;
      end
      S_DN_CMP: begin
        mem_we      = 1'b1;
        map_we      = 1'b1;
        map_valid_w = 1'b1;
        map_pos_w   = p;
        if (best_l || best_r) begin
          mem_wdata  = best;
          map_idx    = best.id[MIW-1:0];
          p_next     = best_l ? lchild[PW-1:0] : rchild[PW-1:0];
          state_next = S_DN;
        end else begin
          map_idx    = cur.id[MIW-1:0];
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  logic [CW+COUNT_W-1:0] count_ext;
  assign count_ext = {{COUNT_W{1'b0}}, count};

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign key_out   = res_key;
  assign id_out    = res_id;
  assign status    = res_status;
  assign count_out = count_ext[COUNT_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= ID_COUNT)
    else $error("entry count above capacity");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && res_status == ST_EMPTY) |-> (count == '0))
    else $error("empty status with entries present");

endmodule

FILE: rtl/indexed_min_heap.sv
// A rejected request goes from S_IDLE straight to S_DONE. Push sifts up, pop reads
// the root and sifts down, and delete first sifts its slot up to the root and then
// removes it as a pop does; each heap level takes a read step and a compare/write
// step on the slot memory.
// One request in flight at a time; done marks the single result cycle, the
// receiver cannot stall. Synchronous reset empties the heap, invalidates every id.
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap with push, pop-minimum and delete-by-id requests.
// ----------------------------------------------------------------------------
module indexed_min_heap #(
  parameter int ID_COUNT = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [ihp_pkg::KEY_W-1:0]     key_in,
  input  logic [ihp_pkg::ID_W-1:0]      id_in,
  output logic                          done,
  output logic [ihp_pkg::KEY_W-1:0]     key_out,
  output logic [ihp_pkg::ID_W-1:0]      id_out,
  output logic [ihp_pkg::STATUS_W-1:0]  status,
  output logic [ihp_pkg::COUNT_W-1:0]   count_out
);
  import ihp_pkg::*;

  localparam int PW = $clog2(ID_COUNT);
  localparam int CW = $clog2(ID_COUNT + 1);

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  slot_t         mem_wdata;
  logic [PW-1:0] mem_raddr_a;
  logic [PW-1:0] mem_raddr_b;
  slot_t         mem_rdata_a;
  slot_t         mem_rdata_b;

  ihp_heap_mem #(
    .DEPTH (ID_COUNT),
    .AW    (PW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  ihp_ctrl #(
    .ID_COUNT (ID_COUNT),
    .KEY_BITS (KEY_BITS),
    .PW       (PW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .key_in      (key_in),
    .id_in       (id_in),
    .done        (done),
    .key_out     (key_out),
    .id_out      (id_out),
    .status      (status),
    .count_out   (count_out),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for indexed_min_heap: drives push, pop and delete requests with
// random gaps, predicts every result from a behavioral heap of its own, and
// checks each done strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
class heap_scoreboard;
  typedef struct {
    logic [15:0] key;
    logic [3:0]  id;
    logic [2:0]  status;
    logic [4:0]  count;
  } heap_result_t;

  ihp_pkg::slot_t slots[16];
  int             pos_of_id[16];
  bit             present[16];
  int             entries;
  heap_result_t   pending[$];
  int             errors;
  int             n_ok, n_empty, n_full, n_absent, n_dup;

  function new();
    entries = 0;
    errors = 0;
    foreach (present[i]) begin
      present[i] = 0;
      pos_of_id[i] = 0;
    end
  endfunction

  function bit slot_lt(ihp_pkg::slot_t a, ihp_pkg::slot_t b);
    return (a.key < b.key) || (a.key == b.key && a.id < b.id);
  endfunction

  function void swap_at(int p, int q);
    ihp_pkg::slot_t t;
    t = slots[p];
    slots[p] = slots[q];
    slots[q] = t;
    pos_of_id[slots[p].id] = p;
    pos_of_id[slots[q].id] = q;
  endfunction

  function void sift_up(int p, bit force_up);
    int par;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (!force_up && !slot_lt(slots[p], slots[par])) break;
      swap_at(p, par);
      p = par;
    end
  endfunction

  function void sift_down(int p);
    int l, r, best;
    forever begin
      l = 2 * p + 1;
      r = l + 1;
      best = p;
      if (l < entries && slot_lt(slots[l], slots[best])) best = l;
      if (r < entries && slot_lt(slots[r], slots[best])) best = r;
      if (best == p) break;
      swap_at(p, best);
      p = best;
    end
  endfunction

  function ihp_pkg::slot_t take_root();
    ihp_pkg::slot_t top;
    top = slots[0];
    present[top.id] = 0;
    pos_of_id[top.id] = 0;
    entries--;
    if (entries > 0) begin
      slots[0] = slots[entries];
      pos_of_id[slots[0].id] = 0;
      sift_down(0);
    end
    return top;
  endfunction

  function void note_request(logic [1:0] op, logic [15:0] key, logic [3:0] id);
    heap_result_t r;
    ihp_pkg::slot_t top;
    int p;
    r.key = 0;
    r.id = 0;
    r.status = ihp_pkg::ST_OK;
    if (op == ihp_pkg::OP_PUSH) begin
      r.key = key;
      r.id = id;
      if (entries >= 16) r.status = ihp_pkg::ST_FULL;
      else if (present[id]) r.status = ihp_pkg::ST_DUP;
      else begin
        p = entries++;
        slots[p].key = key;
        slots[p].id = id;
        pos_of_id[id] = p;
        present[id] = 1;
        sift_up(p, 0);
      end
    end else if (op == ihp_pkg::OP_DELETE) begin
      r.id = id;
      if (!present[id]) r.status = ihp_pkg::ST_ABSENT;
      else begin
        p = pos_of_id[id];
        if (p >= entries) p = 0;
        sift_up(p, 1);
        top = take_root();
        r.key = top.key;
      end
    end else begin
      if (entries == 0) r.status = ihp_pkg::ST_EMPTY;
      else begin
        top = take_root();
        r.key = top.key;
        r.id = top.id;
      end
    end
    r.count = 5'(entries);
    case (r.status)
      ihp_pkg::ST_OK:     n_ok++;
      ihp_pkg::ST_EMPTY:  n_empty++;
      ihp_pkg::ST_FULL:   n_full++;
      ihp_pkg::ST_ABSENT: n_absent++;
      default:            n_dup++;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(logic [15:0] key, logic [3:0] id, logic [2:0] st,
                             logic [4:0] cnt);
    heap_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result key=%h id=%h status=%0d count=%0d",
               $time, key, id, st, cnt);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (key !== e.key) begin
      $display("%0t: key_out expected %h actual %h", $time, e.key, key);
      errors++;
    end
    if (id !== e.id) begin
      $display("%0t: id_out expected %h actual %h", $time, e.id, id);
      errors++;
    end
    if (st !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, st);
      errors++;
    end
    if (cnt !== e.count) begin
      $display("%0t: count_out expected %0d actual %0d", $time, e.count, cnt);
      errors++;
    end
  endfunction
endclass

module tb;
  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [1:0]  operation = 0;
  logic [15:0] key_in = 0;
  logic [3:0]  id_in = 0;
  logic        busy, done;
  logic [15:0] key_out;
  logic [3:0]  id_out;
  logic [2:0]  status;
  logic [4:0]  count_out;

  heap_scoreboard sb = new();
  int idle_cycles = 0;
  int n_requests = 0;

  indexed_min_heap dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .key_in(key_in), .id_in(id_in), .done(done), .key_out(key_out),
    .id_out(id_out), .status(status), .count_out(count_out)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_request(operation, key_in, id_in);
        n_requests++;
      end
      if (done) sb.check_result(key_out, id_out, status, count_out);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 2000) begin
        $display("watchdog timeout");
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  // start held across back-to-back requests; send lowers it only on a gap
  task automatic send(logic [1:0] op, logic [15:0] key, logic [3:0] id, bit gaps);
    operation <= op;
    key_in <= key;
    id_in <= id;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 0;
      random_gap();
    end
  endtask

  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_key();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] rand_op(int fill);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 2'd3;
    if (fill < 8) return (r < 60) ? ihp_pkg::OP_PUSH :
                         (r < 80) ? ihp_pkg::OP_POP : ihp_pkg::OP_DELETE;
    return (r < 35) ? ihp_pkg::OP_PUSH : (r < 70) ? ihp_pkg::OP_POP : ihp_pkg::OP_DELETE;
  endfunction

  initial begin
    int i;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: empty pop, absent delete, fill to full with ties and extremes,
    // overflow, deletes, duplicate, opcode 3, drain
    send(ihp_pkg::OP_POP, 16'h0, 4'h0, 0);
    send(ihp_pkg::OP_DELETE, 16'h0, 4'h5, 0);
    for (i = 0; i < 16; i++)
      send(ihp_pkg::OP_PUSH, (i % 3 == 0) ? 16'hffff : (i % 3 == 1) ? 16'h0 : 16'h5555,
           4'(15 - i), 0);
    send(ihp_pkg::OP_PUSH, 16'h1234, 4'h3, 0);
    drain();
    send(ihp_pkg::OP_DELETE, 16'haaaa, 4'hf, 0);
    send(ihp_pkg::OP_DELETE, 16'h0, 4'h0, 0);
    send(ihp_pkg::OP_PUSH, 16'h8000, 4'h0, 0);
    send(ihp_pkg::OP_PUSH, 16'h0001, 4'h0, 0);
    send(2'd3, 16'h0, 4'h0, 0);
    send(ihp_pkg::OP_DELETE, 16'h0, 4'h0, 0);
    drain();

    for (i = 0; i < 1950; i++) begin
      send(rand_op(sb.entries), rand_key(), 4'($urandom), 1);
      if (i == 1000) drain();
    end
    drain();

    $display("%0d requests: %0d ok, %0d empty, %0d full, %0d absent, %0d duplicate",
             n_requests, sb.n_ok, sb.n_empty, sb.n_full, sb.n_absent, sb.n_dup);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
